// File: hdl/ptk_pkg.sv
`default_nettype none

package ptk_pkg;

  localparam int unsigned DEPTH_BITS = 8;
  localparam int unsigned MAX_RES    = 3;

  // operation codes
  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_EOL  = 2'd1;
  localparam logic [1:0] OP_EOR  = 2'd2;

  // lexer modes
  localparam logic [1:0] MODE_DEFAULT = 2'd0;
  localparam logic [1:0] MODE_STRING  = 2'd1;
  localparam logic [1:0] MODE_LIST    = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_WARN  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // token types
  localparam logic [2:0] TK_IDENT    = 3'd0;
  localparam logic [2:0] TK_STRING   = 3'd1;
  localparam logic [2:0] TK_LIST     = 3'd2;
  localparam logic [2:0] TK_MODIFIER = 3'd3;
  localparam logic [2:0] TK_GROUP    = 3'd4;

  // status codes
  localparam logic [2:0] CODE_NONE       = 3'd0;
  localparam logic [2:0] CODE_BAD_ESC    = 3'd1;
  localparam logic [2:0] CODE_OPEN_STR   = 3'd2;
  localparam logic [2:0] CODE_OPEN_LIST  = 3'd3;
  localparam logic [2:0] CODE_EMPTY_LIT  = 3'd4;

  // characters
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_F      = 8'h66;

  typedef struct packed {
    logic [1:0]            mode;
    logic                  esc;
    logic [7:0]            quote;
    logic [DEPTH_BITS-1:0] level;
    logic [2:0]            kind;
    logic                  nonempty;
    logic                  err;
  } lex_state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [2:0] ttype;
    logic [2:0] code;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] items;
    logic [1:0]         count;
  } res_bundle_t;

  function automatic res_t mk_res(input logic [1:0] kind, input logic [7:0] data,
                                  input logic [2:0] ttype, input logic [2:0] code);
    res_t r;
    r.kind  = kind;
    r.data  = data;
    r.ttype = ttype;
    r.code  = code;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/ptk_step.sv
`default_nettype none

module ptk_step (
  input  wire logic [1:0]          op_i,
  input  wire logic [7:0]          byte_i,
  input  wire ptk_pkg::lex_state_t st_i,
  output ptk_pkg::lex_state_t      st_o,
  output ptk_pkg::res_bundle_t     res_o
);
  import ptk_pkg::*;

  localparam logic [DEPTH_BITS-1:0] LVL_MAX = '1;
  localparam logic [DEPTH_BITS-1:0] LVL_ONE = DEPTH_BITS'(1);

  lex_state_t  nxt;
  res_bundle_t res;
  logic [1:0]  n;
  logic        esc_ok;
  logic [7:0]  esc_val;
  logic [2:0]  grp_t;

  // escaped ordinary byte
  always_comb begin
    esc_ok  = 1'b1;
    esc_val = CH_BSLASH;
    case (byte_i)
      CH_BSLASH: esc_val = CH_BSLASH;
      CH_T:      esc_val = CH_TAB;
      CH_N:      esc_val = CH_LF;
      CH_R:      esc_val = CH_CR;
      CH_V:      esc_val = CH_VT;
      CH_F:      esc_val = CH_FF;
      default:   esc_ok  = 1'b0;
    endcase
  end

  assign grp_t = (byte_i == CH_CARET || byte_i == CH_STAR || byte_i == CH_PLUS) ?
                 TK_MODIFIER : TK_GROUP;

  always_comb begin
    nxt = st_i;
    res = '0;
    n   = 2'd0;
    case (op_i)
      OP_BYTE: begin
        if (!st_i.err) begin
          case (st_i.mode)
            MODE_STRING: begin
              if (byte_i == CH_SQUOTE || byte_i == CH_DQUOTE) begin
                if (byte_i == st_i.quote && !st_i.esc) begin
                  res.items[n] = st_i.nonempty ?
                                 mk_res(KIND_END, 8'h00, st_i.kind, CODE_NONE) :
                                 mk_res(KIND_WARN, 8'h00, st_i.kind, CODE_EMPTY_LIT);
                  n = n + 2'd1;
                  nxt.mode     = MODE_DEFAULT;
                  nxt.kind     = TK_IDENT;
                  nxt.nonempty = 1'b0;
                  nxt.esc      = 1'b0;
                end else begin
                  res.items[n] = mk_res(KIND_BYTE, byte_i, st_i.kind, CODE_NONE);
                  n = n + 2'd1;
                  nxt.nonempty = 1'b1;
                  nxt.esc      = 1'b0;
                end
              end else if (byte_i == CH_BSLASH) begin
                if (st_i.esc) begin
                  res.items[n] = mk_res(KIND_BYTE, CH_BSLASH, st_i.kind, CODE_NONE);
                  n = n + 2'd1;
                  nxt.nonempty = 1'b1;
                  nxt.esc      = 1'b0;
                end else begin
                  nxt.esc = 1'b1;
                end
              end else if (st_i.esc) begin
                if (esc_ok) begin
                  res.items[n] = mk_res(KIND_BYTE, esc_val, st_i.kind, CODE_NONE);
                  nxt.nonempty = 1'b1;
                  nxt.esc      = 1'b0;
                end else begin
                  res.items[n] = mk_res(KIND_ERROR, 8'h00, st_i.kind, CODE_BAD_ESC);
                  nxt.err = 1'b1;
                end
                n = n + 2'd1;
              end else begin
                res.items[n] = mk_res(KIND_BYTE, byte_i, st_i.kind, CODE_NONE);
                n = n + 2'd1;
                nxt.nonempty = 1'b1;
              end
            end
            MODE_LIST: begin
              if (byte_i == CH_LBRACK) begin
                if (st_i.esc) begin
                  nxt.esc = 1'b0;
                end else if (st_i.level < LVL_MAX) begin
                  nxt.level = st_i.level + LVL_ONE;
                end
                res.items[n] = mk_res(KIND_BYTE, byte_i, st_i.kind, CODE_NONE);
                n = n + 2'd1;
                nxt.nonempty = 1'b1;
              end else if (byte_i == CH_RBRACK) begin
                if (st_i.esc) begin
                  res.items[n] = mk_res(KIND_BYTE, byte_i, st_i.kind, CODE_NONE);
                  n = n + 2'd1;
                  nxt.nonempty = 1'b1;
                  nxt.esc      = 1'b0;
                end else begin
                  if (st_i.level != '0) begin
                    nxt.level = st_i.level - LVL_ONE;
                  end
                  if (nxt.level == '0) begin
                    res.items[n] = st_i.nonempty ?
                                   mk_res(KIND_END, 8'h00, st_i.kind, CODE_NONE) :
                                   mk_res(KIND_WARN, 8'h00, st_i.kind, CODE_EMPTY_LIT);
                    nxt.mode     = MODE_DEFAULT;
                    nxt.kind     = TK_IDENT;
                    nxt.nonempty = 1'b0;
                    nxt.esc      = 1'b0;
                  end else begin
                    res.items[n] = mk_res(KIND_BYTE, byte_i, st_i.kind, CODE_NONE);
                    nxt.nonempty = 1'b1;
                  end
                  n = n + 2'd1;
                end
              end else if (byte_i == CH_BSLASH) begin
                if (st_i.esc) begin
                  res.items[n] = mk_res(KIND_BYTE, CH_BSLASH, st_i.kind, CODE_NONE);
                  n = n + 2'd1;
                  nxt.nonempty = 1'b1;
                  nxt.esc      = 1'b0;
                end else begin
                  nxt.esc = 1'b1;
                end
              end else if (st_i.esc) begin
                if (esc_ok) begin
                  res.items[n] = mk_res(KIND_BYTE, esc_val, st_i.kind, CODE_NONE);
                  nxt.nonempty = 1'b1;
                  nxt.esc      = 1'b0;
                end else begin
                  res.items[n] = mk_res(KIND_ERROR, 8'h00, st_i.kind, CODE_BAD_ESC);
                  nxt.err = 1'b1;
                end
                n = n + 2'd1;
              end else begin
                res.items[n] = mk_res(KIND_BYTE, byte_i, st_i.kind, CODE_NONE);
                n = n + 2'd1;
                nxt.nonempty = 1'b1;
              end
            end
            default: begin
              case (byte_i)
                CH_SQUOTE, CH_DQUOTE, CH_LBRACK: begin
                  if (st_i.nonempty) begin
                    res.items[n] = mk_res(KIND_END, 8'h00, TK_IDENT, CODE_NONE);
                    n = n + 2'd1;
                  end
                  nxt.esc      = 1'b0;
                  nxt.nonempty = 1'b0;
                  if (byte_i == CH_LBRACK) begin
                    nxt.mode  = MODE_LIST;
                    nxt.level = LVL_ONE;
                    nxt.kind  = TK_LIST;
                  end else begin
                    nxt.mode  = MODE_STRING;
                    nxt.quote = byte_i;
                    nxt.kind  = TK_STRING;
                  end
                end
                CH_CARET, CH_STAR, CH_PLUS, CH_BAR, CH_LPAREN, CH_RPAREN: begin
                  if (st_i.nonempty) begin
                    res.items[n] = mk_res(KIND_END, 8'h00, TK_IDENT, CODE_NONE);
                    n = n + 2'd1;
                  end
                  res.items[n] = mk_res(KIND_BYTE, byte_i, grp_t, CODE_NONE);
                  n = n + 2'd1;
                  res.items[n] = mk_res(KIND_END, 8'h00, grp_t, CODE_NONE);
                  n = n + 2'd1;
                  nxt.kind     = TK_IDENT;
                  nxt.nonempty = 1'b0;
                end
                CH_TAB, CH_SPACE, CH_CR, CH_LF: begin
                  if (st_i.nonempty) begin
                    res.items[n] = mk_res(KIND_END, 8'h00, TK_IDENT, CODE_NONE);
                    n = n + 2'd1;
                  end
                  nxt.nonempty = 1'b0;
                end
                default: begin
                  res.items[n] = mk_res(KIND_BYTE, byte_i, st_i.kind, CODE_NONE);
                  n = n + 2'd1;
                  nxt.nonempty = 1'b1;
                end
              endcase
            end
          endcase
        end
      end
      OP_EOL, OP_EOR: begin
        if (!st_i.err) begin
          if (st_i.mode == MODE_STRING) begin
            res.items[n] = mk_res(KIND_ERROR, 8'h00, st_i.kind, CODE_OPEN_STR);
            n = n + 2'd1;
            nxt.err = 1'b1;
          end else if (st_i.mode == MODE_LIST) begin
            res.items[n] = mk_res(KIND_ERROR, 8'h00, st_i.kind, CODE_OPEN_LIST);
            n = n + 2'd1;
            nxt.err = 1'b1;
          end else if (op_i == OP_EOR && st_i.nonempty) begin
            res.items[n] = mk_res(KIND_END, 8'h00, TK_IDENT, CODE_NONE);
            n = n + 2'd1;
          end
        end
        if (op_i == OP_EOR) begin
          // rule ends: back to reset state whatever was emitted
          nxt = '0;
        end
      end
      default: begin
      end
    endcase
    res.count = n;
  end

  assign st_o  = nxt;
  assign res_o = res;

endmodule

`default_nettype wire

// File: hdl/ptk_res_buf.sv
`default_nettype none

module ptk_res_buf (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire ptk_pkg::res_bundle_t  res_i,
  output logic                       free_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output ptk_pkg::res_t              res_o,
  output logic                       last_o
);
  import ptk_pkg::*;

  res_t [MAX_RES-1:0] ent_q;
  logic [1:0]         cnt_q, cnt_d;
  logic [1:0]         rd_q, rd_d;
  logic               take, final_take;

  assign out_valid_o = (rd_q != cnt_q);
  assign take        = out_valid_o && out_ready_i;
  assign last_o      = ((rd_q + 2'd1) == cnt_q);
  assign final_take  = take && last_o;
  assign free_o      = !out_valid_o || final_take;
  assign res_o       = ent_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    rd_d  = rd_q;
    if (free_o) begin
      cnt_d = push_i ? res_i.count : 2'd0;
      rd_d  = 2'd0;
    end else if (take) begin
      rd_d = rd_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && push_i) begin
      ent_q <= res_i.items;
    end
  end

endmodule

`default_nettype wire

// File: hdl/peg_rule_tokenizer.sv
// Grammar rule body tokenizer.
// Input channel: in_valid_i/in_ready_o carry one word (operation_i, char_byte_i):
// a text byte, an end of line or an end of rule. Output channel:
// out_valid_o/out_ready_i carry result words (kind, data_byte, token_type,
// code, last); one input word gives zero to three results, last_o marks the
// final one of that input. Words giving no result produce nothing.
// A taken word waits in the input register, is lexed from it once the result
// buffer is free, and its results are registered in the buffer before output.
// Throughput: one input word per cycle while each gives at most one result and
// out_ready_i is high; otherwise the output port, one result per cycle, sets
// the pace: the three-entry result buffer must drain before a word is lexed.
// A new word is taken whenever the input register is empty or moves on.
// Reset clears the lexer state, the input register and the result buffer.
// When the receiver stalls, results hold on the output, the input register
// fills and in_ready_o falls; nothing is dropped.
`default_nettype none

module peg_rule_tokenizer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] operation_i,
  input  wire logic [7:0] char_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      data_byte_o,
  output logic [2:0]      token_type_o,
  output logic [2:0]      code_o,
  output logic            last_o
);
  import ptk_pkg::*;

  logic        in_vld_q;
  logic [1:0]  op_q;
  logic [7:0]  byte_q;
  lex_state_t  st_q, st_d;
  res_bundle_t res;
  res_t        out_res;
  logic        buf_free;
  logic        proc;
  logic        in_take;

  assign proc       = in_vld_q && buf_free;
  assign in_ready_o = !in_vld_q || proc;
  assign in_take    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      st_q     <= '0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (proc) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q   <= operation_i;
      byte_q <= char_byte_i;
    end
  end

  ptk_step u_step (
    .op_i   (op_q),
    .byte_i (byte_q),
    .st_i   (st_q),
    .st_o   (st_d),
    .res_o  (res)
  );

  ptk_res_buf u_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (proc),
    .res_i       (res),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res),
    .last_o      (last_o)
  );

  assign kind_o       = out_res.kind;
  assign data_byte_o  = out_res.data;
  assign token_type_o = out_res.ttype;
  assign code_o       = out_res.code;

`ifndef ASSERT_OFF
  a_byte_no_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_BYTE || kind_o == KIND_END) |-> code_o == CODE_NONE)
    else $error("token byte or end carries a status code");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_ERROR |->
      (code_o == CODE_BAD_ESC || code_o == CODE_OPEN_STR || code_o == CODE_OPEN_LIST))
    else $error("error result with wrong code");

  a_sticky_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && st_q.err |-> res.count == 2'd0)
    else $error("results produced while error is sticky");

  a_eor_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && op_q == OP_EOR |=> st_q == '0)
    else $error("state not cleared at end of rule");
`endif

endmodule

`default_nettype wire

// File: tb/peg_rule_tokenizer_checker.sv
`default_nettype none

module peg_rule_tokenizer_checker (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_ready_i,
  input  wire logic [1:0] operation_i,
  input  wire logic [7:0] char_byte_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_ready_i,
  input  wire logic [1:0] kind_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic [2:0] token_type_i,
  input  wire logic [2:0] code_i,
  input  wire logic       last_i,
  output int              fail_count_o,
  output int              outstanding_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import ptk_pkg::*;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [2:0] ttype;
    logic [2:0] code;
    logic       last;
  } token_res_t;

  token_res_t pending_results[$];
  token_res_t step_results[$];
  int         fails = 0;

  // lexer copy
  logic [1:0]            lx_mode;
  logic                  lx_esc;
  logic [7:0]            lx_quote;
  logic [DEPTH_BITS-1:0] lx_depth;
  logic [2:0]            lx_kind;
  logic                  lx_nonempty;
  logic                  lx_err;

  task automatic put(input logic [1:0] k, input logic [7:0] d, input logic [2:0] t,
                     input logic [2:0] c);
    token_res_t r;
    r.kind  = k;
    r.data  = d;
    r.ttype = t;
    r.code  = c;
    r.last  = 1'b0;
    step_results.insert(step_results.size(), r);
  endtask

  task automatic clear_state();
    lx_mode     = MODE_DEFAULT;
    lx_esc      = 1'b0;
    lx_quote    = 8'h00;
    lx_depth    = '0;
    lx_kind     = TK_IDENT;
    lx_nonempty = 1'b0;
    lx_err      = 1'b0;
  endtask

  task automatic add_byte(input logic [7:0] b);
    put(KIND_BYTE, b, lx_kind, CODE_NONE);
    lx_nonempty = 1'b1;
  endtask

  task automatic end_ident();
    if (lx_nonempty) put(KIND_END, 8'h00, TK_IDENT, CODE_NONE);
    lx_nonempty = 1'b0;
  endtask

  task automatic close_lit();
    if (lx_nonempty) put(KIND_END, 8'h00, lx_kind, CODE_NONE);
    else put(KIND_WARN, 8'h00, lx_kind, CODE_EMPTY_LIT);
    lx_mode     = MODE_DEFAULT;
    lx_kind     = TK_IDENT;
    lx_nonempty = 1'b0;
    lx_esc      = 1'b0;
  endtask

  task automatic flag_error(input logic [2:0] c);
    put(KIND_ERROR, 8'h00, lx_kind, c);
    lx_err = 1'b1;
  endtask

  task automatic check_open();
    if (lx_mode == MODE_STRING) flag_error(CODE_OPEN_STR);
    else if (lx_mode == MODE_LIST) flag_error(CODE_OPEN_LIST);
  endtask

  task automatic single_token(input logic [7:0] c, input logic [2:0] t);
    end_ident();
    put(KIND_BYTE, c, t, CODE_NONE);
    put(KIND_END, 8'h00, t, CODE_NONE);
    lx_kind     = TK_IDENT;
    lx_nonempty = 1'b0;
  endtask

  task automatic backslash();
    if (lx_esc) begin
      add_byte(CH_BSLASH);
      lx_esc = 1'b0;
    end else begin
      lx_esc = 1'b1;
    end
  endtask

  task automatic plain_or_escape(input logic [7:0] c);
    logic [7:0] v;
    logic       good;
    v    = 8'h00;
    good = 1'b1;
    if (lx_esc) begin
      case (c)
        CH_BSLASH: v = CH_BSLASH;
        CH_T:      v = CH_TAB;
        CH_N:      v = CH_LF;
        CH_R:      v = CH_CR;
        CH_V:      v = CH_VT;
        CH_F:      v = CH_FF;
        default:   good = 1'b0;
      endcase
      if (good) begin
        add_byte(v);
        lx_esc = 1'b0;
      end else begin
        flag_error(CODE_BAD_ESC);
      end
    end else begin
      add_byte(c);
    end
  endtask

  // works out every result one input word causes and queues them
  task automatic lex_word(input logic [1:0] op, input logic [7:0] c);
    step_results.delete();
    case (op)
      OP_BYTE: begin
        if (!lx_err) begin
          case (lx_mode)
            MODE_STRING: begin
              if (c == CH_SQUOTE || c == CH_DQUOTE) begin
                // other quote, or an escaped one, stays in the string
                if (c == lx_quote && !lx_esc) begin
                  close_lit();
                end else begin
                  add_byte(c);
                  lx_esc = 1'b0;
                end
              end else if (c == CH_BSLASH) begin
                backslash();
              end else begin
                plain_or_escape(c);
              end
            end
            MODE_LIST: begin
              if (c == CH_LBRACK) begin
                if (lx_esc) lx_esc = 1'b0;
                else if (lx_depth != {DEPTH_BITS{1'b1}}) lx_depth = lx_depth + 1'b1;
                add_byte(c);
              end else if (c == CH_RBRACK) begin
                if (lx_esc) begin
                  add_byte(c);
                  lx_esc = 1'b0;
                end else begin
                  if (lx_depth != '0) lx_depth = lx_depth - 1'b1;
                  if (lx_depth == '0) close_lit();
                  else add_byte(c);
                end
              end else if (c == CH_BSLASH) begin
                backslash();
              end else begin
                plain_or_escape(c);
              end
            end
            default: begin
              case (c)
                CH_SQUOTE, CH_DQUOTE: begin
                  end_ident();
                  lx_mode     = MODE_STRING;
                  lx_esc      = 1'b0;
                  lx_quote    = c;
                  lx_kind     = TK_STRING;
                  lx_nonempty = 1'b0;
                end
                CH_LBRACK: begin
                  end_ident();
                  lx_mode     = MODE_LIST;
                  lx_esc      = 1'b0;
                  lx_depth    = DEPTH_BITS'(1);
                  lx_kind     = TK_LIST;
                  lx_nonempty = 1'b0;
                end
                CH_CARET, CH_STAR, CH_PLUS: single_token(c, TK_MODIFIER);
                CH_BAR, CH_LPAREN, CH_RPAREN: single_token(c, TK_GROUP);
                CH_TAB, CH_SPACE, CH_CR, CH_LF: end_ident();
                default: add_byte(c);
              endcase
            end
          endcase
        end
      end
      OP_EOL: if (!lx_err) check_open();
      OP_EOR: begin
        if (!lx_err) begin
          if (lx_mode == MODE_DEFAULT) end_ident();
          else check_open();
        end
        clear_state();
      end
      default: ;
    endcase
    if (step_results.size() > 0) begin
      step_results[step_results.size() - 1].last = 1'b1;
    end
    foreach (step_results[i]) begin
      pending_results.insert(pending_results.size(), step_results[i]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_b
    token_res_t want;
    if (!rst_ni) begin
      pending_results.delete();
      clear_state();
      fails = 0;
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      // results leave only after their word has passed the input register and the result buffer, so compare first
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result kind=%0d data=%h type=%0d code=%0d last=%0b",
                   $time, kind_i, data_byte_i, token_type_i, code_i, last_i);
          fails++;
        end else begin
          want = pending_results.pop_front();
          if (want.kind !== kind_i || want.data !== data_byte_i ||
              want.ttype !== token_type_i || want.code !== code_i ||
              want.last !== last_i) begin
            $display("%0t: mismatch expected kind=%0d data=%h type=%0d code=%0d last=%0b",
                     $time, want.kind, want.data, want.ttype, want.code, want.last);
            $display("%0t:          actual   kind=%0d data=%h type=%0d code=%0d last=%0b",
                     $time, kind_i, data_byte_i, token_type_i, code_i, last_i);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) lex_word(operation_i, char_byte_i);
      fail_count_o  <= fails;
      outstanding_o <= pending_results.size();
    end
  end

endmodule

`default_nettype wire

// File: tb/tb_peg_rule_tokenizer.sv
`default_nettype none

module tb_peg_rule_tokenizer;

  import ptk_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         RANDOM_WORDS = 280;
  localparam int         NEST_LEVELS  = 6;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       out_ready_i = 1'b0;
  logic [1:0] operation_i = OP_BYTE;
  logic [7:0] char_byte_i = 8'h00;

  wire logic       in_ready_o;
  wire logic       out_valid_o;
  wire logic [1:0] kind_o;
  wire logic [7:0] data_byte_o;
  wire logic [2:0] token_type_o;
  wire logic [2:0] code_o;
  wire logic       last_o;

  int fail_count;
  int outstanding;
  int idle_pct   = 0;
  int stall_pct  = 0;
  int hold_req   = 0;
  int hold_done  = 0;
  int words_sent = 0;

  always #4 clk_i = ~clk_i;

  peg_rule_tokenizer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .char_byte_i  (char_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .data_byte_o  (data_byte_o),
    .token_type_o (token_type_o),
    .code_o       (code_o),
    .last_o       (last_o)
  );

  peg_rule_tokenizer_checker u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .operation_i   (operation_i),
    .char_byte_i   (char_byte_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_i        (kind_o),
    .data_byte_i   (data_byte_o),
    .token_type_i  (token_type_o),
    .code_i        (code_o),
    .last_i        (last_o),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_done) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done++;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_word(input logic [1:0] op, input logic [7:0] c);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    char_byte_i <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (op != OP_UNUSED) words_sent++;
  endtask

  task automatic send_char(input logic [7:0] c);
    send_word(OP_BYTE, c);
  endtask

  // stop offering words until every result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [7:0] word_char();
    logic [7:0] b;
    logic       ok;
    b  = 8'h00;
    ok = 1'b0;
    while (!ok) begin
      b = 8'($urandom_range(255));
      case (b)
        CH_SQUOTE, CH_DQUOTE, CH_LBRACK, CH_RBRACK, CH_BSLASH, CH_CARET, CH_STAR,
        CH_PLUS, CH_BAR, CH_LPAREN, CH_RPAREN, CH_TAB, CH_LF, CH_CR, CH_SPACE: ok = 1'b0;
        default: ok = 1'b1;
      endcase
    end
    return b;
  endfunction

  function automatic logic [7:0] misc_char();
    case ($urandom_range(14))
      0:       return CH_SQUOTE;
      1:       return CH_DQUOTE;
      2:       return CH_LBRACK;
      3:       return CH_RBRACK;
      4:       return CH_BSLASH;
      5:       return CH_CARET;
      6:       return CH_STAR;
      7:       return CH_PLUS;
      8:       return CH_BAR;
      9:       return CH_LPAREN;
      10:      return CH_RPAREN;
      11:      return CH_TAB;
      12:      return CH_LF;
      13:      return CH_CR;
      default: return CH_SPACE;
    endcase
  endfunction

  // byte to follow a backslash; mostly valid escapes
  function automatic logic [7:0] esc_char(input logic [7:0] closer);
    case ($urandom_range(11))
      0:       return CH_BSLASH;
      1:       return CH_T;
      2:       return CH_N;
      3:       return CH_R;
      4:       return CH_V;
      5:       return CH_F;
      6, 7:    return closer;
      8:       return CH_LBRACK;
      9:       return CH_SQUOTE;
      10:      return CH_DQUOTE;
      default: return word_char();
    endcase
  endfunction

  task automatic send_string();
    logic [7:0] q;
    logic [7:0] other;
    q     = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
    other = (q == CH_SQUOTE) ? CH_DQUOTE : CH_SQUOTE;
    send_char(q);
    repeat ($urandom_range(4)) begin
      case ($urandom_range(6))
        0:       send_char(other);
        1: begin
          send_char(CH_BSLASH);
          send_char(esc_char(q));
        end
        2:       send_char(misc_char());
        default: send_char(word_char());
      endcase
    end
    case ($urandom_range(9))
      0:       send_word(OP_EOL, 8'($urandom_range(255)));
      1:       ;
      default: send_char(q);
    endcase
  endtask

  task automatic send_list();
    int lvl;
    lvl = 1;
    send_char(CH_LBRACK);
    repeat ($urandom_range(5)) begin
      case ($urandom_range(7))
        0: begin
          send_char(CH_LBRACK);
          lvl++;
        end
        1: begin
          if (lvl > 1) begin
            send_char(CH_RBRACK);
            lvl--;
          end else begin
            send_char(word_char());
          end
        end
        2: begin
          send_char(CH_BSLASH);
          send_char(esc_char(CH_RBRACK));
        end
        3:       send_char(misc_char());
        default: send_char(word_char());
      endcase
    end
    case ($urandom_range(9))
      0:       send_word(OP_EOL, 8'($urandom_range(255)));
      1:       ;
      default: repeat (lvl) send_char(CH_RBRACK);
    endcase
  endtask

  task automatic send_rule();
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(9))
        0, 1:    repeat ($urandom_range(1, 4)) send_char(word_char());
        2, 3:    send_char(misc_char());
        4, 5:    send_string();
        6:       send_list();
        7:       send_word(OP_EOL, 8'($urandom_range(255)));
        8:       send_word(2'($urandom_range(3)), 8'($urandom_range(255)));
        default: send_char(word_char());
      endcase
    end
    if ($urandom_range(7) != 0) send_word(OP_EOR, 8'($urandom_range(255)));
  endtask

  initial begin
    int target;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words, no idling
    send_char("a");
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CH_SPACE);
    send_word(OP_EOL, 8'h00);
    send_word(OP_UNUSED, 8'hFF);
    send_char(CH_STAR);
    send_char(CH_RPAREN);
    send_char(CH_DQUOTE);
    send_char(CH_SQUOTE);    // other quote kept
    send_char(CH_BSLASH);
    send_char(CH_SQUOTE);    // escaped other quote
    send_char(CH_BSLASH);
    send_char(CH_DQUOTE);    // escaped closing quote
    send_char(CH_DQUOTE);
    send_char(CH_LBRACK);
    send_char(CH_BSLASH);
    send_char(CH_LBRACK);    // escaped open bracket, level stays
    send_char(CH_RBRACK);
    send_char(CH_SQUOTE);
    send_char(CH_SQUOTE);    // empty string
    send_char(CH_LBRACK);
    send_word(OP_EOL, 8'h00); // open list at end of line
    send_char("x");          // swallowed while the error stands
    send_word(OP_EOR, 8'h00);
    send_char("w");
    send_word(OP_EOR, 8'hFF);
    drain();

    // nested list closed level by level
    repeat (NEST_LEVELS) send_char(CH_LBRACK);
    repeat (NEST_LEVELS) send_char(CH_RBRACK);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          hold_req++;
        end
        1: begin
          idle_pct  = 71;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 71;
        end
        default: begin
          idle_pct  = 36;
          stall_pct = 36;
        end
      endcase
      target = words_sent + RANDOM_WORDS / 4;
      while (words_sent < target) send_rule();
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
